>>> hw/rtl/sfr_pkg.sv
// shared types and constants for the stream find-and-replace block
package sfr_pkg;

   // size limits
   localparam int WIN_DEPTH       = 8;
   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int PLEN_LIMIT      = (MAX_PATTERN < WIN_DEPTH) ? MAX_PATTERN : WIN_DEPTH;
   localparam int RLEN_LIMIT      = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;

   // configuration register indexes
   localparam logic [7:0] REG_PATTERN_LENGTH     = 8'd0;
   localparam logic [7:0] REG_PATTERN_BYTES      = 8'd1;
   localparam logic [7:0] REG_REPLACEMENT_LENGTH = 8'd2;
   localparam logic [7:0] REG_REPLACEMENT_BYTES  = 8'd3;

   typedef logic [7:0][7:0] bytes8_type;

   // one queued job: bytes to release, then replacement or end marker
   typedef struct packed {
      bytes8_type window;
      logic [3:0] nrel;
      logic [3:0] total;
      logic       eos;
   } job_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_EVAL
   } front_state_type;

endpackage

>>> hw/rtl/sfr_queue.sv
// two-entry job queue between the front and back parts
module sfr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfr_pkg::job_type push_job,
   input  logic             pop,
   output sfr_pkg::job_type pop_job,
   output logic             full,
   output logic             empty
);

   sfr_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   assign full    = (fill_ff == 2'd2);
   assign empty   = (fill_ff == 2'd0);
   assign pop_job = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hw/rtl/sfr_front.sv
// front part: accepts bytes, keeps the pending window and classifies each step
module sfr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic [3:0]         plen,
   input  sfr_pkg::bytes8_type pattern,
   input  logic [3:0]         rlen,
   output logic               push,
   output sfr_pkg::job_type   push_job,
   input  logic               q_full
);

   sfr_pkg::front_state_type state_ff, state_in;
   sfr_pkg::bytes8_type      win_ff, win_in;
   logic [3:0]               count_ff, count_in;
   logic                     eos_ff, eos_in;

   logic [7:0] eq [8];
   logic [3:0] k;
   logic       match;
   logic [3:0] nrel;
   logic [3:0] total;
   logic       need_push;

   // byte compares of every window shift against the pattern
   always_comb begin
      for (int s = 0; s < 8; s++) begin
         for (int j = 0; j < 8; j++) begin
            if (s + j < 8) begin
               eq[s][j] = (win_ff[3'(s + j)] == pattern[j]);
            end else begin
               eq[s][j] = 1'b0;
            end
         end
      end
   end

   // first shift that leaves a live prefix or a full match
   always_comb begin
      logic [3:0] rem;
      logic       pre;
      logic       hit;
      k     = count_ff;
      match = 1'b0;
      for (int s = 7; s >= 0; s--) begin
         rem = count_ff - 4'(s);
         pre = (4'(s) <= count_ff) && (rem <= plen);
         for (int j = 0; j < 8; j++) begin
            if ((4'(j) < rem) && !eq[s][j]) begin
               pre = 1'b0;
            end
         end
         hit = pre && ((rem < plen) || ((s == 0) && (rem == plen)));
         if (hit) begin
            k     = 4'(s);
            match = (s == 0) && (rem == plen);
         end
      end
   end

   // job summary
   always_comb begin
      nrel      = eos_ff ? count_ff : k;
      total     = match ? rlen : nrel;
      need_push = (total != 4'd0) || eos_ff;
      push_job.window = win_ff;
      push_job.nrel   = match ? 4'd0 : nrel;
      push_job.total  = total;
      push_job.eos    = eos_ff;
   end

   // front control
   always_comb begin
      logic [4:0] src;
      state_in   = state_ff;
      win_in     = win_ff;
      count_in   = count_ff;
      eos_in     = eos_ff;
      req_tready = 1'b0;
      push       = 1'b0;
      case (state_ff)
         sfr_pkg::FRONT_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               win_in[count_ff[2:0]] = req_tdata;
               count_in = count_ff + 4'd1;
               eos_in   = req_tlast;
               state_in = sfr_pkg::FRONT_EVAL;
            end
         end
         sfr_pkg::FRONT_EVAL: begin
            if (!need_push || !q_full) begin
               push     = need_push;
               state_in = sfr_pkg::FRONT_IDLE;
               if (match || eos_ff) begin
                  count_in = 4'd0;
               end else begin
                  count_in = count_ff - k;
                  for (int j = 0; j < 8; j++) begin
                     src = 5'(j) + {1'b0, k};
                     if (src < 5'd8) begin
                        win_in[j] = win_ff[src[2:0]];
                     end
                  end
               end
            end
         end
         default: begin
            state_in = sfr_pkg::FRONT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfr_pkg::FRONT_IDLE;
         count_ff <= 4'd0;
         eos_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         eos_ff   <= eos_in;
      end
   end

   // window bytes
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

>>> hw/rtl/sfr_back.sv
// back part: plays out each job as result transactions through an output register
module sfr_back (
   input  logic               clock,
   input  logic               reset,
   input  sfr_pkg::job_type   pop_job,
   input  logic               q_empty,
   output logic               pop,
   input  sfr_pkg::bytes8_type replacement,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic [1:0]         rsp_tuser,
   output logic               rsp_tlast
);

   sfr_pkg::job_type job_ff, job_in;
   logic             active_ff, active_in;
   logic [3:0]       idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       data_ff, data_in;
   logic [1:0]       user_ff, user_in;
   logic             last_ff, last_in;

   logic             load;
   logic             item_last;
   logic [3:0]       ridx;

   assign load      = !valid_ff || rsp_tready;
   assign item_last = (job_ff.total == 4'd0) || (idx_ff == job_ff.total - 4'd1);
   assign ridx      = idx_ff - job_ff.nrel;

   // job sequencing and result build
   always_comb begin
      job_in    = job_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      data_in   = data_ff;
      user_in   = user_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = 1'b0;
      end
      if (!active_ff) begin
         if (!q_empty) begin
            pop       = 1'b1;
            job_in    = pop_job;
            active_in = 1'b1;
            idx_in    = 4'd0;
         end
      end else if (load) begin
         valid_in = 1'b1;
         if (job_ff.total == 4'd0) begin
            data_in = 8'd0;
         end else if (idx_ff < job_ff.nrel) begin
            data_in = job_ff.window[idx_ff[2:0]];
         end else begin
            data_in = replacement[ridx[2:0]];
         end
         user_in[0] = (job_ff.total != 4'd0);
         user_in[1] = item_last && job_ff.eos;
         last_in    = item_last;
         idx_in     = idx_ff + 4'd1;
         if (item_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      idx_ff  <= idx_in;
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> hw/rtl/stream_find_and_replace.sv
// top level of the stream find-and-replace block
//
// Bytes of a text enter on the req_ stream, one per transaction, with tlast
// marking the final byte. Every leftmost, non-overlapping match of the
// configured pattern is replaced; all other bytes pass unchanged. Results
// leave on the rsp_ stream, one byte per transaction; tlast marks the last
// result caused by an input byte and tuser[1] the last one of the text.
// A text end with nothing left to send gives one bare marker (tuser[0] low).
// The csr_ channel writes the four registers and is always ready; the user
// must write it only while the block is idle; the block does not enforce it.
// In the front part each input byte is captured, then compared in parallel
// at all window shifts against the pattern; no new byte is taken until the
// front is done with it. A job then waits in a two-entry queue; the back
// part loads it into its job register and emits its results one per cycle
// while the receiver is ready.
// A stalled receiver holds the output register; the queue then fills and the
// front stops taking bytes. Reset empties the window, the queue and the
// output, and restores pattern length 1 with all other registers zero.
module stream_find_and_replace (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [0] has_byte, [1] stream_done
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [3:0]          plen_reg_ff;
   sfr_pkg::bytes8_type pattern_ff;
   logic [3:0]          rlen_reg_ff;
   sfr_pkg::bytes8_type replacement_ff;

   logic [3:0]          plen;
   logic [3:0]          rlen;

   logic                push;
   logic                pop;
   logic                q_full;
   logic                q_empty;
   sfr_pkg::job_type    push_job;
   sfr_pkg::job_type    pop_job;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_reg_ff    <= 4'd1;
         pattern_ff     <= '0;
         rlen_reg_ff    <= 4'd0;
         replacement_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            sfr_pkg::REG_PATTERN_LENGTH:     plen_reg_ff    <= csr_wdata[3:0];
            sfr_pkg::REG_PATTERN_BYTES:      pattern_ff     <= csr_wdata;
            sfr_pkg::REG_REPLACEMENT_LENGTH: rlen_reg_ff    <= csr_wdata[3:0];
            sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective lengths
   always_comb begin
      if (plen_reg_ff == 4'd0) begin
         plen = 4'd1;
      end else if (plen_reg_ff > 4'(sfr_pkg::PLEN_LIMIT)) begin
         plen = 4'(sfr_pkg::PLEN_LIMIT);
      end else begin
         plen = plen_reg_ff;
      end
      if (rlen_reg_ff > 4'(sfr_pkg::RLEN_LIMIT)) begin
         rlen = 4'(sfr_pkg::RLEN_LIMIT);
      end else begin
         rlen = rlen_reg_ff;
      end
   end

   sfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .plen       (plen),
      .pattern    (pattern_ff),
      .rlen       (rlen),
      .push       (push),
      .push_job   (push_job),
      .q_full     (q_full)
   );

   sfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   sfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_job     (pop_job),
      .q_empty     (q_empty),
      .pop         (pop),
      .replacement (replacement_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

>>> hw/rtl/sfr_checker.sv
// port-level checks for the stream find-and-replace block
module sfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast,
   input logic        csr_valid,
   input logic        csr_ready
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a bare marker closes the text and carries zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tuser[1] && (rsp_tdata == 8'd0))
      else $error("bad end marker");

   // end of text is always the last result of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("stream done without last");

   // input is never taken in back-to-back transfers
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken in back-to-back cycles");

   // configuration is never stalled
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind stream_find_and_replace sfr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
